// File: rtl/multi_channel_tachometer_assert.svh
// ----------------------------------------------------------------------------
// Tachometer assertion macros
// Shared concurrent assertion forms used by the tachometer top level.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_TACHOMETER_ASSERT_SVH
`define MULTI_CHANNEL_TACHOMETER_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define MCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tachometer check failed");

// next-cycle implication checked outside reset
`define MCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tachometer check failed");

`endif

// File: rtl/mct_pkg.sv
// ----------------------------------------------------------------------------
// Tachometer package
// Shared constants, types and state codes for the tachometer block.
// ----------------------------------------------------------------------------
package mct_pkg;

  localparam int unsigned Channels = 4;
  localparam int unsigned ChW = 2;
  localparam int unsigned Depth = 4;
  localparam int unsigned PosW = 2;
  localparam int unsigned CntW = 3;
  localparam int unsigned DivW = 26;
  localparam logic [15:0] RpmMax = 16'hFFFF;
  localparam logic [5:0] SecPerMin = 6'd60;

  localparam logic [1:0] RegTickRate = 2'd0;
  localparam logic [1:0] RegPulses = 2'd1;
  localparam logic [1:0] RegTimeout = 2'd2;

  localparam logic CmdCapture = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAPTURE,
    ST_CHECK,
    ST_DIV1,
    ST_DIV2,
    ST_STORE,
    ST_AVG,
    ST_EMIT
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic do_capture;
    logic do_timeout;
    logic start_div1;
    logic start_div2;
    logic div_step;
    logic store_rpm;
    logic avg_step;
    logic load_out;
    logic clr_ch;
    logic inc_ch;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_tick;
    logic timed_out;
    logic pending;
    logic div_done;
    logic avg_done;
    logic last_ch;
  } stat_t;

endpackage

// File: rtl/mct_ctrl.sv
// ----------------------------------------------------------------------------
// Tachometer controller
// Sequences capture handling and the per-channel tick evaluation.
// ----------------------------------------------------------------------------
module mct_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_full_i,
  input  mct_pkg::stat_t  stat_i,
  output mct_pkg::ctrl_t  ctrl_o
);

  mct_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mct_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      mct_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load_in = 1'b1;
          state_d = mct_pkg::ST_CAPTURE;
        end
      end
      mct_pkg::ST_CAPTURE: begin
        if (stat_i.is_tick) begin
          ctrl_o.clr_ch = 1'b1;
          state_d = mct_pkg::ST_CHECK;
        end else begin
          ctrl_o.do_capture = 1'b1;
          state_d = mct_pkg::ST_IDLE;
        end
      end
      mct_pkg::ST_CHECK: begin
        if (stat_i.timed_out) begin
          ctrl_o.do_timeout = 1'b1;
          state_d = mct_pkg::ST_EMIT;
        end else if (stat_i.pending) begin
          ctrl_o.start_div1 = 1'b1;
          state_d = mct_pkg::ST_DIV1;
        end else begin
          state_d = mct_pkg::ST_EMIT;
        end
      end
      mct_pkg::ST_DIV1: begin
        if (stat_i.div_done) begin
          ctrl_o.start_div2 = 1'b1;
          state_d = mct_pkg::ST_DIV2;
        end else begin
          ctrl_o.div_step = 1'b1;
        end
      end
      mct_pkg::ST_DIV2: begin
        if (stat_i.div_done) begin
          ctrl_o.store_rpm = 1'b1;
          state_d = mct_pkg::ST_AVG;
        end else begin
          ctrl_o.div_step = 1'b1;
        end
      end
      mct_pkg::ST_AVG: begin
        if (stat_i.avg_done) begin
          state_d = mct_pkg::ST_EMIT;
        end else begin
          ctrl_o.avg_step = 1'b1;
        end
      end
      mct_pkg::ST_EMIT: begin
        if (!out_full_i) begin
          ctrl_o.load_out = 1'b1;
          if (stat_i.last_ch) begin
            state_d = mct_pkg::ST_IDLE;
          end else begin
            ctrl_o.inc_ch = 1'b1;
            state_d = mct_pkg::ST_CHECK;
          end
        end
      end
      default: state_d = mct_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/mct_datapath.sv
// ----------------------------------------------------------------------------
// Tachometer datapath
// Channel state, shared restoring divider, window averaging and output stage.
// ----------------------------------------------------------------------------
module mct_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mct_pkg::ctrl_t           ctrl_i,
  output mct_pkg::stat_t           stat_o,
  input  logic                     command_i,
  input  logic [1:0]               channel_sel_i,
  input  logic [15:0]              capture_value_i,
  input  logic [31:0]              time_ms_i,
  input  logic [19:0]              tick_rate_q_i,
  input  logic [4:0]               pulses_q_i,
  input  logic [15:0]              timeout_q_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [1:0]               out_channel_o,
  output logic [15:0]              rpm_now_o,
  output logic [15:0]              rpm_avg_o,
  output logic                     present_o,
  output logic                     timed_out_o,
  output logic                     last_o
);

  localparam int unsigned N = mct_pkg::Channels;
  localparam int unsigned D = mct_pkg::Depth;
  localparam int unsigned W = mct_pkg::DivW;

  // latched input item
  logic        cmd_q;
  logic [1:0]  sel_q;
  logic [15:0] cap_q;
  logic [31:0] now_q;

  // per-channel state
  logic [15:0] prev_q   [N];
  logic [15:0] period_q [N];
  logic [31:0] edge_q   [N];
  logic [N-1:0] first_q, pend_q, pres_q, tmo_q;
  logic [15:0] win_q [N][D];
  logic [mct_pkg::CntW-1:0] cnt_q [N];
  logic [mct_pkg::PosW-1:0] pos_q [N];
  logic [15:0] now_st_q [N];
  logic [15:0] avg_st_q [N];

  logic [mct_pkg::ChW-1:0] ch_q;

  // divider
  logic [W-1:0] quo_q, rem_q, dvs_q;
  logic [4:0]   dcnt_q;
  logic         dbusy_q;

  // averaging
  logic [17:0] sum_q;
  logic [mct_pkg::CntW-1:0] acnt_q;
  logic [2:0]  aidx_q;
  logic        aphase_q;

  logic [31:0] elapsed;
  logic [W-1:0] rem_sh, rem_sub;
  logic [W-1:0] dividend1;
  logic [15:0] rpm_sat;
  logic [4:0] ppt;
  logic [17:0] sum_next;
  logic [mct_pkg::PosW-1:0] wr_pos;

  assign elapsed = now_q - edge_q[ch_q];
  assign dividend1 = W'(tick_rate_q_i) * W'(mct_pkg::SecPerMin);
  assign ppt = (pulses_q_i == 5'd0) ? 5'd1 : pulses_q_i;
  assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
  assign rem_sub = rem_sh - dvs_q;
  assign rpm_sat = (quo_q > W'(mct_pkg::RpmMax)) ? mct_pkg::RpmMax : quo_q[15:0];
  assign wr_pos = pos_q[ch_q];

  assign stat_o.is_tick = cmd_q;
  assign stat_o.timed_out = !first_q[ch_q] && (elapsed > {16'd0, timeout_q_i});
  assign stat_o.pending = pend_q[ch_q];
  assign stat_o.div_done = dbusy_q && (dcnt_q == 5'd0);
  assign stat_o.avg_done = aphase_q;
  assign stat_o.last_ch = (ch_q == mct_pkg::ChW'(N - 1));

  // input latch
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      cmd_q <= command_i;
      sel_q <= channel_sel_i;
      cap_q <= capture_value_i;
      now_q <= time_ms_i;
    end
  end

  // channel counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
    end else if (ctrl_i.clr_ch) begin
      ch_q <= '0;
    end else if (ctrl_i.inc_ch) begin
      ch_q <= ch_q + 1'b1;
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      dcnt_q <= '0;
      quo_q <= '0;
      rem_q <= '0;
      dvs_q <= '0;
    end else if (ctrl_i.start_div1) begin
      dbusy_q <= 1'b1;
      dcnt_q <= 5'(W);
      quo_q <= dividend1;
      rem_q <= '0;
      dvs_q <= W'(period_q[ch_q]);
    end else if (ctrl_i.start_div2) begin
      dcnt_q <= 5'(W);
      rem_q <= '0;
      dvs_q <= W'(ppt);
    end else if (ctrl_i.div_step) begin
      dcnt_q <= dcnt_q - 1'b1;
      if (rem_sh >= dvs_q) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end else if (ctrl_i.store_rpm) begin
      dbusy_q <= 1'b0;
    end
  end

  // window sum then mean by a small constant-divisor select
  assign sum_next = sum_q + 18'(win_q[ch_q][aidx_q[mct_pkg::PosW-1:0]]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aphase_q <= 1'b0;
      aidx_q <= '0;
      sum_q <= '0;
      acnt_q <= '0;
    end else if (ctrl_i.store_rpm) begin
      aphase_q <= 1'b0;
      aidx_q <= '0;
      sum_q <= '0;
      acnt_q <= (cnt_q[ch_q] < mct_pkg::CntW'(D)) ? cnt_q[ch_q] + 1'b1 : cnt_q[ch_q];
    end else if (ctrl_i.avg_step) begin
      if (aidx_q < 3'(acnt_q)) begin
        sum_q <= sum_next;
        aidx_q <= aidx_q + 1'b1;
      end else begin
        aphase_q <= 1'b1;
      end
    end else begin
      aphase_q <= 1'b0;
    end
  end

  // divide by three as multiply by (2^19 + 1) / 3, exact for an 18-bit sum
  function automatic logic [15:0] mean_f(input logic [17:0] s,
                                         input logic [mct_pkg::CntW-1:0] c);
    logic [35:0] m;
    begin
      m = '0;
      case (c)
        3'd1: mean_f = s[15:0];
        3'd2: mean_f = s[16:1];
        3'd3: begin
          m = 36'(s) * 36'd174763;
          mean_f = m[34:19];
        end
        3'd4: mean_f = s[17:2];
        default: mean_f = 16'd0;
      endcase
    end
  endfunction

  // channel state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '1;
      pend_q <= '0;
      pres_q <= '0;
      tmo_q <= '0;
      for (int c = 0; c < N; c++) begin
        prev_q[c] <= '0;
        period_q[c] <= '0;
        edge_q[c] <= '0;
        cnt_q[c] <= '0;
        pos_q[c] <= '0;
        now_st_q[c] <= '0;
        avg_st_q[c] <= '0;
        for (int k = 0; k < D; k++) win_q[c][k] <= '0;
      end
    end else begin
      if (ctrl_i.do_capture) begin
        prev_q[sel_q] <= cap_q;
        edge_q[sel_q] <= now_q;
        if (first_q[sel_q]) begin
          first_q[sel_q] <= 1'b0;
          pres_q[sel_q] <= 1'b1;
          tmo_q[sel_q] <= 1'b0;
        end else if (cap_q != prev_q[sel_q]) begin
          period_q[sel_q] <= cap_q - prev_q[sel_q];
          pend_q[sel_q] <= 1'b1;
        end
      end
      if (ctrl_i.do_timeout) begin
        now_st_q[ch_q] <= '0;
        avg_st_q[ch_q] <= '0;
        pres_q[ch_q] <= 1'b0;
        tmo_q[ch_q] <= 1'b1;
        pend_q[ch_q] <= 1'b0;
        cnt_q[ch_q] <= '0;
        pos_q[ch_q] <= '0;
        for (int k = 0; k < D; k++) win_q[ch_q][k] <= '0;
      end
      if (ctrl_i.store_rpm) begin
        pend_q[ch_q] <= 1'b0;
        now_st_q[ch_q] <= rpm_sat;
        win_q[ch_q][wr_pos] <= rpm_sat;
        pos_q[ch_q] <= wr_pos + 1'b1;
        if (cnt_q[ch_q] < mct_pkg::CntW'(D)) cnt_q[ch_q] <= cnt_q[ch_q] + 1'b1;
        pres_q[ch_q] <= 1'b1;
        tmo_q[ch_q] <= 1'b0;
      end
      if (ctrl_i.avg_step && !(aidx_q < 3'(acnt_q))) begin
        avg_st_q[ch_q] <= mean_f(sum_q, acnt_q);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (ctrl_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      out_channel_o <= ch_q;
      rpm_now_o <= now_st_q[ch_q];
      rpm_avg_o <= avg_st_q[ch_q];
      present_o <= pres_q[ch_q];
      timed_out_o <= tmo_q[ch_q];
      last_o <= (ch_q == mct_pkg::ChW'(N - 1));
    end
  end

endmodule

// File: rtl/multi_channel_tachometer.sv
// Sequence: a capture passes through the idle and capture states; a tick
// checks each channel in turn and, where a period is pending, runs two
// divisions on the shared bit-serial divider and the window sum before its
// result. No new transaction is accepted until the controller is back in
// idle, and output stalls hold it in the emit state.
// Reset: rst_ni clears all channel state and restores register defaults.
// ----------------------------------------------------------------------------
// Tachometer top level
// Four-channel fan tachometer with APB configuration registers.
// ----------------------------------------------------------------------------
`include "multi_channel_tachometer_assert.svh"

module multi_channel_tachometer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [1:0]  channel_sel_i,
  input  logic [15:0] capture_value_i,
  input  logic [31:0] time_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_channel_o,
  output logic [15:0] rpm_now_o,
  output logic [15:0] rpm_avg_o,
  output logic        present_o,
  output logic        timed_out_o,
  output logic        last_o
);

  logic [19:0] tick_rate_q;
  logic [4:0]  pulses_q;
  logic [15:0] timeout_q;
  mct_pkg::ctrl_t ctrl;
  mct_pkg::stat_t stat;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= 20'd125000;
      pulses_q <= 5'd2;
      timeout_q <= 16'd1200;
    end else if (wr_en && paddr[1:0] == 2'd0) begin
      unique case (paddr[3:2])
        mct_pkg::RegTickRate: tick_rate_q <= pwdata[19:0];
        mct_pkg::RegPulses:   pulses_q <= pwdata[4:0];
        mct_pkg::RegTimeout:  timeout_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      mct_pkg::RegTickRate: prdata = {12'd0, tick_rate_q};
      mct_pkg::RegPulses:   prdata = {27'd0, pulses_q};
      mct_pkg::RegTimeout:  prdata = {16'd0, timeout_q};
      default:              prdata = 32'd0;
    endcase
  end

  mct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_full_i (out_valid_o && !out_ready_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  mct_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .command_i       (command_i),
    .channel_sel_i   (channel_sel_i),
    .capture_value_i (capture_value_i),
    .time_ms_i       (time_ms_i),
    .tick_rate_q_i   (tick_rate_q),
    .pulses_q_i      (pulses_q),
    .timeout_q_i     (timeout_q),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .out_channel_o   (out_channel_o),
    .rpm_now_o       (rpm_now_o),
    .rpm_avg_o       (rpm_avg_o),
    .present_o       (present_o),
    .timed_out_o     (timed_out_o),
    .last_o          (last_o)
  );

  // no result is loaded while a new transaction can be taken
  `MCT_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, in_ready_o, !ctrl.load_out)
  // a result is only loaded when the output register is free
  `MCT_ASSERT_IMP(a_load_free, clk_i, rst_ni, ctrl.load_out, !out_valid_o || out_ready_i)
  // acceptance moves the controller out of idle
  `MCT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule
